>>> design/gwd_pkg.sv
// ----------------------------------------------------------------------------
// gwd_pkg
// Shared types, constants and calendar tables for the Gregorian weekday unit.
// ----------------------------------------------------------------------------
package gwd_pkg;

  // Default width of the year field.
  localparam int YEAR_BITS_DEF = 14;

  // First year for which a weekday is given.
  localparam int FIRST_YEAR = 1600;

  // Division by 25 as a multiply by a reciprocal and a right shift.
  // Exact for dividends below 43690, which covers a year of up to 16 bits
  // after it has been divided by four.
  localparam logic [12:0] DIV25_MUL   = 13'd5243;
  localparam int          DIV25_SHIFT = 17;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_MONTH  = 2'd1,
    ST_BAD_DAY    = 2'd2,
    ST_EARLY_YEAR = 2'd3
  } status_t;

  // Month numbers.
  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_FEB = 4'd2;
  localparam logic [3:0] MON_MAR = 4'd3;
  localparam logic [3:0] MON_APR = 4'd4;
  localparam logic [3:0] MON_MAY = 4'd5;
  localparam logic [3:0] MON_JUN = 4'd6;
  localparam logic [3:0] MON_JUL = 4'd7;
  localparam logic [3:0] MON_AUG = 4'd8;
  localparam logic [3:0] MON_SEP = 4'd9;
  localparam logic [3:0] MON_OCT = 4'd10;
  localparam logic [3:0] MON_NOV = 4'd11;
  localparam logic [3:0] MON_DEC = 4'd12;

  // Number of days in a month; February depends on the leap flag.
  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Weekday offset of each month's start, used with the March-based year.
  function automatic logic [2:0] month_shift(input logic [3:0] month);
    logic [2:0] sh;
    case (month)
      MON_JAN: sh = 3'd0;
      MON_FEB: sh = 3'd3;
      MON_MAR: sh = 3'd2;
      MON_APR: sh = 3'd5;
      MON_MAY: sh = 3'd0;
      MON_JUN: sh = 3'd3;
      MON_JUL: sh = 3'd5;
      MON_AUG: sh = 3'd1;
      MON_SEP: sh = 3'd4;
      MON_OCT: sh = 3'd6;
      MON_NOV: sh = 3'd2;
      MON_DEC: sh = 3'd4;
      default: sh = 3'd0;
    endcase
    return sh;
  endfunction

endpackage

>>> design/gwd_in_if.sv
// ----------------------------------------------------------------------------
// gwd_in_if
// Valid/ready channel that carries one date word.
// ----------------------------------------------------------------------------
interface gwd_in_if
  import gwd_pkg::*;
#(
  parameter int YEAR_BITS = YEAR_BITS_DEF
);

  logic                 valid;
  logic                 ready;
  logic [4:0]           day_of_month;
  logic [3:0]           month_number;
  logic [YEAR_BITS-1:0] year_number;

  modport source (
    output valid, day_of_month, month_number, year_number,
    input  ready
  );

  modport sink (
    input  valid, day_of_month, month_number, year_number,
    output ready
  );

endinterface

>>> design/gwd_out_if.sv
// ----------------------------------------------------------------------------
// gwd_out_if
// Valid/ready channel that carries one result word: status and weekday.
// ----------------------------------------------------------------------------
interface gwd_out_if;

  logic       valid;
  logic       ready;
  logic [1:0] status_code;
  logic [2:0] weekday;

  modport source (
    output valid, status_code, weekday,
    input  ready
  );

  modport sink (
    input  valid, status_code, weekday,
    output ready
  );

endinterface

>>> design/gregorian_weekday_from_date.sv
// ----------------------------------------------------------------------------
// gregorian_weekday_from_date
// Checks a day, month and year and gives the Gregorian weekday (0 is Sunday).
// The unit is a four-stage pipeline: it takes one date word in every cycle
// and sustains one result word per cycle as long as the result side keeps
// taking words. The stages are: a reciprocal multiply that divides the
// year by 100, the month, day and year checks with the leap rule, the
// day-count sum, and a mod-7 fold that feeds the output register. Each stage
// stalls only when the stage after it is full and stalled, so bubbles are
// squeezed out and a date is still accepted while a finished result waits.
// The status is 0 for a good date, 1 for a bad month, 2 for a bad day and 3
// for a year before 1600; the weekday is 0 whenever the status is not 0.
// ----------------------------------------------------------------------------
module gregorian_weekday_from_date
  import gwd_pkg::*;
#(
  parameter int YEAR_BITS = YEAR_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  gwd_in_if.sink           dates,
  gwd_out_if.source        results
);

  // Quotient of a year by 100, product width of the reciprocal multiply,
  // width of the day-count sum and number of octal digits in it.
  localparam int QW = YEAR_BITS - 6;
  localparam int PW = YEAR_BITS + 11;
  localparam int SW = YEAR_BITS + 2;
  localparam int ND = (SW + 2) / 3;

  // Stage valid bits and advance enables.
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1 registers.
  logic [4:0]           d1;
  logic [3:0]           m1;
  logic [YEAR_BITS-1:0] y1;
  logic [QW-1:0]        q1;

  // Stage 2 registers.
  status_t              status2;
  logic [YEAR_BITS-1:0] yy2;
  logic [QW-1:0]        qy2;
  logic [5:0]           sd2;

  // Stage 3 registers.
  status_t              status3;
  logic [SW-1:0]        sum3;

  // Stage 4 (output) registers.
  status_t              status4;
  logic [2:0]           wd4;

  // Combinational signals.
  logic [PW-1:0]        prod;
  logic [QW-1:0]        q_in;
  logic [YEAR_BITS-1:0] hund;
  logic                 century;
  logic                 leap;
  logic                 march_based;
  logic                 month_ok;
  logic                 day_ok;
  logic                 year_ok;
  status_t              status_next;
  logic [YEAR_BITS-1:0] yy_next;
  logic [QW-1:0]        qy_next;
  logic [5:0]           sd_next;
  logic [SW-1:0]        sum_next;
  logic [3*ND-1:0]      sum_pad;
  logic [5:0]           digit_sum;
  logic [3:0]           fold;
  logic [2:0]           wd_next;

  // Handshake: a stage loads when it is empty or its contents move on.
  assign rdy4          = !v4 || results.ready;
  assign rdy3          = !v3 || rdy4;
  assign rdy2          = !v2 || rdy3;
  assign rdy1          = !v1 || rdy2;
  assign dates.ready   = rdy1;
  assign results.valid = v4;
  assign results.status_code = status4;
  assign results.weekday     = wd4;

  // Stage 1: year divided by 100 as (year / 4) / 25 by reciprocal multiply.
  assign prod = PW'(dates.year_number >> 2) * PW'(DIV25_MUL);
  assign q_in = prod[DIV25_SHIFT +: QW];

  // Stage 2: leap rule, date checks and the March-based year.
  always_comb begin
    hund        = YEAR_BITS'({q1, 6'b0}) + YEAR_BITS'({q1, 5'b0}) + YEAR_BITS'({q1, 2'b0});
    century     = (y1 == hund);
    leap        = (y1[1:0] == 2'b00) && (!century || (q1[1:0] == 2'b00));
    month_ok    = (m1 >= MON_JAN) && (m1 <= MON_DEC);
    day_ok      = (d1 != 5'd0) && (d1 <= month_days(m1, leap));
    year_ok     = (y1 >= YEAR_BITS'(FIRST_YEAR));
    march_based = (m1 < MON_MAR);
    if (!month_ok) begin
      status_next = ST_BAD_MONTH;
    end else if (!day_ok) begin
      status_next = ST_BAD_DAY;
    end else if (!year_ok) begin
      status_next = ST_EARLY_YEAR;
    end else begin
      status_next = ST_OK;
    end
    // January and February count in the previous year.
    yy_next = march_based ? (y1 - YEAR_BITS'(1)) : y1;
    qy_next = (march_based && century) ? (q1 - QW'(1)) : q1;
    sd_next = 6'(month_shift(m1)) + 6'(d1);
  end

  // Stage 3: day count yy + yy/4 - yy/100 + yy/400 + shift + day.
  assign sum_next = SW'(yy2) + SW'(yy2 >> 2) - SW'(qy2) + SW'(qy2 >> 2) + SW'(sd2);

  // Stage 4: mod 7 by summing octal digits, since 8 is 1 modulo 7.
  assign sum_pad = (3*ND)'(sum3);
  always_comb begin
    digit_sum = '0;
    for (int i = 0; i < ND; i++) begin
      digit_sum = digit_sum + 6'(sum_pad[3*i +: 3]);
    end
    fold    = 4'(digit_sum[5:3]) + 4'(digit_sum[2:0]);
    wd_next = (fold >= 4'd7) ? 3'(fold - 4'd7) : fold[2:0];
  end

  // Pipeline registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= dates.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
    if (rdy1) begin
      d1 <= dates.day_of_month;
      m1 <= dates.month_number;
      y1 <= dates.year_number;
      q1 <= q_in;
    end
    if (rdy2) begin
      status2 <= status_next;
      yy2     <= yy_next;
      qy2     <= qy_next;
      sd2     <= sd_next;
    end
    if (rdy3) begin
      status3 <= status2;
      sum3    <= sum_next;
    end
    if (rdy4) begin
      status4 <= status3;
      wd4     <= (status3 == ST_OK) ? wd_next : 3'd0;
    end
  end

`ifndef SYNTHESIS
  // A failed check never carries a weekday.
  assert property (@(posedge clk) disable iff (rst)
    (v4 && (status4 != ST_OK)) |-> (wd4 == 3'd0))
    else $error("weekday set on a result word with a bad status");

  // The weekday always lies in Sunday through Saturday.
  assert property (@(posedge clk) disable iff (rst)
    v4 |-> (wd4 <= 3'd6))
    else $error("weekday out of range");

  // Reset empties the pipeline.
  assert property (@(posedge clk)
    $past(rst) |-> (!v1 && !v2 && !v3 && !v4))
    else $error("pipeline not empty after reset");

  // A full pipeline with a stalled output takes no new date word.
  assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && !results.ready) |-> !dates.ready)
    else $error("date word accepted into a full, stalled pipeline");

  // A word in stage 2 moves to stage 3 whenever stage 3 can take it.
  assert property (@(posedge clk) disable iff (rst)
    (v2 && rdy3) |=> v3)
    else $error("word lost between stage 2 and stage 3");
`endif

endmodule
